// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the bus decoder.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge once reset is released.
`define ASSERT_RUN(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/bdoam_pkg.sv =====
// Package of the bus decoder with sprite-table DMA: command codes, target codes,
// memory-map constants, the per-beat result record and the I/O register decoder.
// Depends on nothing.
package bdoam_pkg;

    // Command codes carried in s_tuser.
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Target codes of a routed request.
    localparam logic [3:0] TGT_NONE    = 4'd0;
    localparam logic [3:0] TGT_BOOTROM = 4'd1;
    localparam logic [3:0] TGT_BANK0   = 4'd2;
    localparam logic [3:0] TGT_BANK1   = 4'd3;
    localparam logic [3:0] TGT_CRAM    = 4'd4;
    localparam logic [3:0] TGT_VRAM    = 4'd5;
    localparam logic [3:0] TGT_OAM     = 4'd6;
    localparam logic [3:0] TGT_JOYPAD  = 4'd7;
    localparam logic [3:0] TGT_SERIAL  = 4'd8;
    localparam logic [3:0] TGT_TIMER   = 4'd9;
    localparam logic [3:0] TGT_AUDIO   = 4'd10;
    localparam logic [3:0] TGT_WAVE    = 4'd11;
    localparam logic [3:0] TGT_VIDEO   = 4'd12;
    localparam logic [3:0] TGT_IRQ_REQ = 4'd13;
    localparam logic [3:0] TGT_IRQ_EN  = 4'd14;

    // Page boundaries of the memory map (high address byte) and low-byte limits in the top pages.
    localparam logic [7:0] PG_BANK1 = 8'h40;
    localparam logic [7:0] PG_VRAM  = 8'h80;
    localparam logic [7:0] PG_CRAM  = 8'hA0;
    localparam logic [7:0] PG_WRAM  = 8'hC0;
    localparam logic [7:0] PG_OAM   = 8'hFE;
    localparam logic [7:0] PG_TOP   = 8'hFF;
    localparam logic [7:0] OAM_END  = 8'hA0;
    localparam logic [7:0] LO_IE    = 8'hFF;

    // Internal I/O registers.
    localparam logic [6:0] REG_DMA  = 7'h46;
    localparam logic [6:0] REG_BOOT = 7'h50;

    // Storage sizes and defaults.
    localparam int WRAM_DEPTH  = 8192;
    localparam int HRAM_DEPTH  = 128;
    localparam int WRAM_AW     = 13;
    localparam int HRAM_AW     = 7;
    localparam int DMA_LEN_DEF = 160;
    localparam logic [7:0] BYTE_OPEN = 8'hFF;

    // Where the inside answer of a beat comes from.
    typedef enum logic [1:0] {
        SRC_FIXED,
        SRC_WRAM,
        SRC_HRAM
    } rd_src_t;

    // One result beat before the memory data is merged in.
    typedef struct packed {
        logic [3:0]  target;
        logic [13:0] offset;
        logic        is_write;
        logic [7:0]  store_data;
        logic [7:0]  read_data;
        logic        answered_inside;
        logic        dma_copy;
        logic [7:0]  sprite_index;
        rd_src_t     rsrc;
    } res_t;

    // Target of an I/O register in the top page; TGT_NONE if it is not routed out.
    function automatic logic [3:0] io_target(input logic [6:0] io_reg);
        logic [3:0] t;
        unique case (io_reg) inside
            7'h00:                     t = TGT_JOYPAD;
            7'h01, 7'h02:              t = TGT_SERIAL;
            [7'h04:7'h07]:             t = TGT_TIMER;
            7'h0F:                     t = TGT_IRQ_REQ;
            [7'h10:7'h26]:             t = TGT_AUDIO;
            [7'h30:7'h3F]:             t = TGT_WAVE;
            [7'h40:7'h45], [7'h47:7'h4B]: t = TGT_VIDEO;
            default:                   t = TGT_NONE;
        endcase
        return t;
    endfunction

endpackage

// ===== hw/rtl/bdoam_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for work RAM and high RAM of the bus decoder; depends on nothing.
module bdoam_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/bus_decoder_with_oam_dma.sv =====
// Channel   Dir  tdata (low bit up)                    tuser / side
// s_*       in   address[15:0], write_data[23:16]      s_tuser[1:0] = cmd
// m_*       out  target[3:0], offset[17:4],            m_tuser = is_write[0],
//                store_data[25:18], read_data[33:26],  answered_inside[1],
//                sprite_index[41:34], zero pad to 48   dma_copy[2]
// One beat is accepted per clock unless the clearing pass or an output stall holds it.
// The decode runs between the input and a stage register, and the work RAM and
// high RAM read ports are read alongside it and merged into the output register.
// After reset a clearing pass writes zero to all 8192 work RAM bytes (and high
// RAM alongside), one byte per cycle, with s_tready low until the pass ends.
// A stall on the output holds the stage register and then the input.
// Depends on bdoam_pkg, bdoam_ram and assert_macros.svh.
`include "assert_macros.svh"

module bus_decoder_with_oam_dma
    import bdoam_pkg::*;
#(
    parameter int DMA_LENGTH = DMA_LEN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // address[15:0], write_data[23:16]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // target, offset, store_data, read_data, sprite_index
    output logic [2:0]  m_tuser    // is_write, answered_inside, dma_copy
);

    localparam int REM_W = $clog2(DMA_LENGTH + 1);

    // Input fields.
    logic [1:0]  in_cmd;
    logic [15:0] in_addr;
    logic [7:0]  in_wdata;
    assign in_cmd   = s_tuser;
    assign in_addr  = s_tdata[15:0];
    assign in_wdata = s_tdata[23:16];

    // Control and architectural state.
    logic                 clr_busy_reg, clr_busy_next;
    logic [WRAM_AW-1:0]   clr_addr_reg, clr_addr_next;
    logic [REM_W-1:0]     dma_rem_reg, dma_rem_next;
    logic [7:0]           dma_page_reg, dma_page_next;
    logic                 boot_reg, boot_next;
    logic                 p1_valid_reg, p1_valid_next;
    res_t                 p1_res_reg;
    logic                 out_valid_reg, out_valid_next;
    res_t                 out_res_reg, out_res_next;

    logic accept;
    logic p1_adv;
    logic dma_active;
    logic [REM_W-1:0] dma_idx;
    logic [7:0]       sprite_idx;
    logic [15:0]      rd_addr;
    logic [7:0]       rd_hi, rd_lo, wr_hi, wr_lo;
    logic [3:0]       rd_io_tgt, wr_io_tgt;

    res_t res_rd, res_wr, res;
    logic has_res, wr_has;
    logic wr_wram, wr_hram, wr_dma, wr_boot;
    logic do_wram_we, do_hram_we, do_dma_start, do_boot_clr, do_tick;

    logic [7:0] wram_q, hram_q;

    // Handshake: the stage register frees up when it moves to the output.
    assign p1_adv     = p1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready   = !clr_busy_reg && (!p1_valid_reg || p1_adv);
    assign accept     = s_tvalid && s_tready;
    assign dma_active = (dma_rem_reg != '0);

    // DMA source: the next byte of the selected page.
    assign dma_idx    = REM_W'(DMA_LENGTH) - dma_rem_reg;
    assign sprite_idx = 8'(dma_idx);
    assign rd_addr    = (in_cmd == CMD_TICK) ? {dma_page_reg, sprite_idx} : in_addr;
    assign rd_hi      = rd_addr[15:8];
    assign rd_lo      = rd_addr[7:0];
    assign wr_hi      = in_addr[15:8];
    assign wr_lo      = in_addr[7:0];
    assign rd_io_tgt  = io_target(rd_lo[6:0]);
    assign wr_io_tgt  = io_target(wr_lo[6:0]);

    // Read decode of the memory map.
    always_comb begin
        res_rd = '0;
        res_rd.rsrc = SRC_FIXED;
        if (rd_hi == 8'h00 && boot_reg) begin
            res_rd.target = TGT_BOOTROM;
            res_rd.offset = {6'd0, rd_lo};
        end else if (rd_hi < PG_BANK1) begin
            res_rd.target = TGT_BANK0;
            res_rd.offset = rd_addr[13:0];
        end else if (rd_hi < PG_VRAM) begin
            res_rd.target = TGT_BANK1;
            res_rd.offset = rd_addr[13:0];
        end else if (rd_hi < PG_CRAM) begin
            res_rd.target = TGT_VRAM;
            res_rd.offset = {1'b0, rd_addr[12:0]};
        end else if (rd_hi < PG_WRAM) begin
            res_rd.target = TGT_CRAM;
            res_rd.offset = {1'b0, rd_addr[12:0]};
        end else if (rd_hi < PG_OAM) begin
            res_rd.answered_inside = 1'b1;
            res_rd.rsrc = SRC_WRAM;
        end else if (rd_hi == PG_OAM) begin
            if (rd_lo < OAM_END) begin
                res_rd.target = TGT_OAM;
                res_rd.offset = {6'd0, rd_lo};
            end else begin
                res_rd.answered_inside = 1'b1;
            end
        end else if (rd_lo == LO_IE) begin
            res_rd.target = TGT_IRQ_EN;
        end else if (rd_lo[7]) begin
            res_rd.answered_inside = 1'b1;
            res_rd.rsrc = SRC_HRAM;
        end else if (rd_io_tgt != TGT_NONE) begin
            res_rd.target = rd_io_tgt;
            res_rd.offset = {7'd0, rd_lo[6:0]};
        end else begin
            res_rd.answered_inside = 1'b1;
            if (rd_lo[6:0] == REG_DMA) begin
                res_rd.read_data = dma_page_reg;
            end else if (rd_lo[6:0] == REG_BOOT) begin
                res_rd.read_data = {7'd0, boot_reg};
            end else begin
                res_rd.read_data = BYTE_OPEN;
            end
        end
    end

    // Write decode: routed requests and the internal stores they touch.
    always_comb begin
        res_wr = '0;
        res_wr.rsrc = SRC_FIXED;
        res_wr.is_write = 1'b1;
        res_wr.store_data = in_wdata;
        wr_has  = 1'b0;
        wr_wram = 1'b0;
        wr_hram = 1'b0;
        wr_dma  = 1'b0;
        wr_boot = 1'b0;
        if (wr_hi < PG_BANK1) begin
            wr_has = 1'b1;
            res_wr.target = TGT_BANK0;
            res_wr.offset = in_addr[13:0];
        end else if (wr_hi < PG_VRAM) begin
            wr_has = 1'b1;
            res_wr.target = TGT_BANK1;
            res_wr.offset = in_addr[13:0];
        end else if (wr_hi < PG_CRAM) begin
            wr_has = 1'b1;
            res_wr.target = TGT_VRAM;
            res_wr.offset = {1'b0, in_addr[12:0]};
        end else if (wr_hi < PG_WRAM) begin
            wr_has = 1'b1;
            res_wr.target = TGT_CRAM;
            res_wr.offset = {1'b0, in_addr[12:0]};
        end else if (wr_hi < PG_OAM) begin
            wr_wram = 1'b1;
        end else if (wr_hi == PG_OAM) begin
            if (wr_lo < OAM_END) begin
                wr_has = 1'b1;
                res_wr.target = TGT_OAM;
                res_wr.offset = {6'd0, wr_lo};
            end
        end else if (wr_lo == LO_IE) begin
            wr_has = 1'b1;
            res_wr.target = TGT_IRQ_EN;
        end else if (wr_lo[7]) begin
            wr_hram = 1'b1;
        end else if (wr_io_tgt != TGT_NONE) begin
            wr_has = 1'b1;
            res_wr.target = wr_io_tgt;
            res_wr.offset = {7'd0, wr_lo[6:0]};
        end else if (wr_lo[6:0] == REG_DMA) begin
            wr_dma = 1'b1;
        end else if (wr_lo[6:0] == REG_BOOT) begin
            wr_boot = (in_wdata != 8'd0);
        end
    end

    // Per-command selection; a running DMA blocks the processor side.
    always_comb begin
        res          = '0;
        res.rsrc     = SRC_FIXED;
        has_res      = 1'b0;
        do_wram_we   = 1'b0;
        do_hram_we   = 1'b0;
        do_dma_start = 1'b0;
        do_boot_clr  = 1'b0;
        do_tick      = 1'b0;
        case (in_cmd)
            CMD_READ: begin
                has_res = 1'b1;
                if (!dma_active) begin
                    res = res_rd;
                end else begin
                    res.answered_inside = 1'b1;
                    if (rd_hi == PG_TOP && rd_lo[7] && rd_lo != LO_IE) begin
                        res.rsrc = SRC_HRAM;
                    end else begin
                        res.read_data = BYTE_OPEN;
                    end
                end
            end
            CMD_WRITE: begin
                if (!dma_active) begin
                    res          = res_wr;
                    has_res      = wr_has;
                    do_wram_we   = wr_wram;
                    do_hram_we   = wr_hram;
                    do_dma_start = wr_dma;
                    do_boot_clr  = wr_boot;
                end
            end
            CMD_TICK: begin
                if (dma_active) begin
                    res              = res_rd;
                    res.dma_copy     = 1'b1;
                    res.sprite_index = sprite_idx;
                    has_res          = 1'b1;
                    do_tick          = 1'b1;
                end
            end
            default: begin
                has_res = 1'b0;
            end
        endcase
    end

    // Work RAM and high RAM; the clearing pass owns the write ports after reset.
    bdoam_ram #(
        .DATA_W(8),
        .DEPTH (WRAM_DEPTH)
    ) u_wram (
        .aclk (aclk),
        .we   (clr_busy_reg || (accept && do_wram_we)),
        .waddr(clr_busy_reg ? clr_addr_reg : in_addr[WRAM_AW-1:0]),
        .wdata(clr_busy_reg ? 8'd0 : in_wdata),
        .re   (accept && res.rsrc == SRC_WRAM),
        .raddr(rd_addr[WRAM_AW-1:0]),
        .rdata(wram_q)
    );

    bdoam_ram #(
        .DATA_W(8),
        .DEPTH (HRAM_DEPTH)
    ) u_hram (
        .aclk (aclk),
        .we   (clr_busy_reg || (accept && do_hram_we)),
        .waddr(clr_busy_reg ? clr_addr_reg[HRAM_AW-1:0] : in_addr[HRAM_AW-1:0]),
        .wdata(clr_busy_reg ? 8'd0 : in_wdata),
        .re   (accept && res.rsrc == SRC_HRAM),
        .raddr(rd_addr[HRAM_AW-1:0]),
        .rdata(hram_q)
    );

    // Next state of the control registers.
    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            clr_busy_next = (clr_addr_reg != '1);
        end

        dma_rem_next  = dma_rem_reg;
        dma_page_next = dma_page_reg;
        boot_next     = boot_reg;
        if (accept && do_tick) begin
            dma_rem_next = dma_rem_reg - 1'b1;
        end
        if (accept && do_dma_start) begin
            dma_rem_next  = REM_W'(DMA_LENGTH);
            dma_page_next = in_wdata;
        end
        if (accept && do_boot_clr) begin
            boot_next = 1'b0;
        end

        if (accept) begin
            p1_valid_next = has_res;
        end else if (p1_adv) begin
            p1_valid_next = 1'b0;
        end else begin
            p1_valid_next = p1_valid_reg;
        end

        if (p1_adv) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Merge the memory answer into the beat leaving the stage register.
    always_comb begin
        out_res_next = p1_res_reg;
        case (p1_res_reg.rsrc)
            SRC_WRAM: out_res_next.read_data = wram_q;
            SRC_HRAM: out_res_next.read_data = hram_q;
            default:  out_res_next.read_data = p1_res_reg.read_data;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            dma_rem_reg   <= '0;
            dma_page_reg  <= 8'd0;
            boot_reg      <= 1'b1;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            clr_busy_reg  <= clr_busy_next;
            clr_addr_reg  <= clr_addr_next;
            dma_rem_reg   <= dma_rem_next;
            dma_page_reg  <= dma_page_next;
            boot_reg      <= boot_next;
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_res_reg <= res;
        end
        if (p1_adv) begin
            out_res_reg <= out_res_next;
        end
    end

    // Output beat.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_res_reg.sprite_index, out_res_reg.read_data,
                       out_res_reg.store_data, out_res_reg.offset, out_res_reg.target};
    assign m_tuser  = {out_res_reg.dma_copy, out_res_reg.answered_inside,
                       out_res_reg.is_write};

    // Checks on the control logic.
    `ASSERT_ALWAYS(a_no_accept_in_clear, aclk, clr_busy_reg |-> !s_tready, "beat taken during clear")
    `ASSERT_RUN(a_dma_bound, aclk, aresetn, dma_rem_reg <= REM_W'(DMA_LENGTH), "DMA count too big")
    `ASSERT_RUN(a_dma_step, aclk, aresetn, (accept && do_tick) |=> (dma_rem_reg == $past(dma_rem_reg) - 1'b1), "DMA count did not step")
    `ASSERT_RUN(a_stage_hold, aclk, aresetn, (p1_valid_reg && !p1_adv) |=> p1_valid_reg, "stage beat lost")

endmodule
